### rtl/core/fpnc_pkg.sv
// ----------------------------------------------------------------------------
// fpnc_pkg
// Shared constants, types and helpers for the Fitch parsimony node combine.
// ----------------------------------------------------------------------------
package fpnc_pkg;

	localparam int MAX_CHILDREN = 4;
	localparam int NUM_STATES   = 5;
	localparam int SET_W        = 5;
	localparam int NODE_SET_W   = 8;
	localparam int SLOT_W       = 3;
	localparam int MASK_W       = 4;
	localparam int COST_W       = 32;
	localparam int WEIGHT_W     = 16;
	localparam int CNT_W        = $clog2(MAX_CHILDREN + 1);
	localparam int HALF         = MAX_CHILDREN / 2;
	localparam int PAIR_W       = COST_W + $clog2(HALF) + 1;
	localparam int SUM_W        = PAIR_W + 1;
	localparam int FACTOR_W     = CNT_W;
	localparam int PROD_W       = WEIGHT_W + FACTOR_W;
	localparam int TOTAL_W      = SUM_W + 1;

	localparam logic [SET_W-1:0]      SET_PURINE     = 5'h05;
	localparam logic [SET_W-1:0]      SET_PYRIMIDINE = 5'h0a;
	localparam logic [NODE_SET_W-1:0] SET_NONE       = 8'hff;
	localparam logic [COST_W-1:0]     COST_MAX       = '1;

	typedef logic [SET_W-1:0] set_t;
	typedef logic [COST_W-1:0] cost_t;

	typedef struct packed {
		logic [SLOT_W-1:0]       slots;
		logic                    root;
		logic [NODE_SET_W-1:0]   inter;
		logic [PAIR_W-1:0]       sum_lo;
		logic [PAIR_W-1:0]       sum_hi;
	} prep_t;

	function automatic set_t fold_set(input set_t s);
		set_t r;
		if ((s & SET_PURINE) != '0) begin
			r = SET_PURINE;
		end else if ((s & SET_PYRIMIDINE) != '0) begin
			r = SET_PYRIMIDINE;
		end else begin
			r = s;
		end
		return r;
	endfunction

endpackage

### rtl/core/fitch_parsimony_node_combine_top.sv
// ----------------------------------------------------------------------------
// fitch_parsimony_node_combine_top
// Combines the state sets and step counts of the subtrees around one interior
// node for one alignment site, giving the node's state set and step count.
// ----------------------------------------------------------------------------
// The block takes one site transaction per clock unless in_stall is high and
// returns its result through a four-stage pipeline: slot preparation, state
// counts and cost sum, plurality and step factor, weighting and saturation.
// The sustained rate is one transaction per cycle whenever the output side is
// not stalled; the input side stalls only when all four stages hold data and
// the output is stalled. The user must write the transversion_mode register
// through the cfg channel only while idle; the block does not enforce it.
module fitch_parsimony_node_combine_top
	import fpnc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [SLOT_W-1:0]     slot_count,
	input  logic [MASK_W-1:0]     present_mask,
	input  logic [SET_W-1:0]      child_set_0,
	input  logic [SET_W-1:0]      child_set_1,
	input  logic [SET_W-1:0]      child_set_2,
	input  logic [SET_W-1:0]      child_set_3,
	input  logic [COST_W-1:0]     child_cost_0,
	input  logic [COST_W-1:0]     child_cost_1,
	input  logic [COST_W-1:0]     child_cost_2,
	input  logic [COST_W-1:0]     child_cost_3,
	input  logic [WEIGHT_W-1:0]   site_weight,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [NODE_SET_W-1:0] node_set,
	output logic [COST_W-1:0]     node_cost
);

	logic transversion_mode_q;

	set_t  sets_in [MAX_CHILDREN];
	cost_t costs_in [MAX_CHILDREN];
	set_t  sets_masked [MAX_CHILDREN];
	prep_t prep;

	logic en_s1, en_s2, en_s3, en_s4;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [SLOT_W-1:0]     slots_s1;
	logic                  root_s1;
	logic [NODE_SET_W-1:0] inter_s1;
	set_t                  sets_s1 [MAX_CHILDREN];
	logic [PAIR_W-1:0]     sum_lo_s1;
	logic [PAIR_W-1:0]     sum_hi_s1;
	logic [WEIGHT_W-1:0]   weight_s1;

	logic [SLOT_W-1:0]     slots_s2;
	logic                  root_s2;
	logic [NODE_SET_W-1:0] inter_s2;
	set_t                  union_s2;
	logic [CNT_W-1:0]      counts_s2 [NUM_STATES];
	logic [SUM_W-1:0]      cost_s2;
	logic [WEIGHT_W-1:0]   weight_s2;

	logic [NODE_SET_W-1:0] node_set_s3;
	logic [FACTOR_W-1:0]   factor_s3;
	logic [SUM_W-1:0]      cost_s3;
	logic [WEIGHT_W-1:0]   weight_s3;

	logic [NODE_SET_W-1:0] node_set_s4;
	logic [COST_W-1:0]     node_cost_s4;

	logic [CNT_W-1:0]      counts_c [NUM_STATES];
	logic [CNT_W-1:0]      largest_c;
	set_t                  plural_c;
	logic [SLOT_W:0]       sub_c;
	logic [NODE_SET_W-1:0] node_set_c;
	logic [FACTOR_W-1:0]   factor_c;
	logic [PROD_W-1:0]     prod_c;
	logic [TOTAL_W-1:0]    total_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transversion_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			transversion_mode_q <= cfg_data;
		end
	end

	assign sets_in[0]  = child_set_0;
	assign sets_in[1]  = child_set_1;
	assign sets_in[2]  = child_set_2;
	assign sets_in[3]  = child_set_3;
	assign costs_in[0] = child_cost_0;
	assign costs_in[1] = child_cost_1;
	assign costs_in[2] = child_cost_2;
	assign costs_in[3] = child_cost_3;

	fpnc_slot_prep u_slot_prep (
		.slot_count        (slot_count),
		.present_mask      (present_mask),
		.transversion_mode (transversion_mode_q),
		.sets              (sets_in),
		.costs             (costs_in),
		.sets_masked       (sets_masked),
		.prep              (prep)
	);

	assign en_s4    = !v_s4 || !out_stall;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			slots_s1  <= prep.slots;
			root_s1   <= prep.root;
			inter_s1  <= prep.inter;
			sets_s1   <= sets_masked;
			sum_lo_s1 <= prep.sum_lo;
			sum_hi_s1 <= prep.sum_hi;
			weight_s1 <= site_weight;
		end
	end

	always_comb begin
		for (int j = 0; j < NUM_STATES; j++) begin
			counts_c[j] = '0;
			for (int k = 0; k < MAX_CHILDREN; k++) begin
				counts_c[j] = counts_c[j] + CNT_W'(sets_s1[k][j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			slots_s2  <= slots_s1;
			root_s2   <= root_s1;
			inter_s2  <= inter_s1;
			union_s2  <= sets_s1[0] | sets_s1[1];
			counts_s2 <= counts_c;
			cost_s2   <= SUM_W'(sum_lo_s1) + SUM_W'(sum_hi_s1);
			weight_s2 <= weight_s1;
		end
	end

	always_comb begin
		largest_c = '0;
		for (int j = 0; j < NUM_STATES; j++) begin
			if (counts_s2[j] > largest_c) begin
				largest_c = counts_s2[j];
			end
		end
		for (int j = 0; j < NUM_STATES; j++) begin
			plural_c[j] = (counts_s2[j] == largest_c);
		end
		sub_c = (SLOT_W+1)'(largest_c) + (SLOT_W+1)'(root_s2);
		if (inter_s2 != '0) begin
			node_set_c = inter_s2;
			factor_c   = '0;
		end else if (slots_s2 == SLOT_W'(2)) begin
			node_set_c = {{(NODE_SET_W-SET_W){1'b0}}, union_s2};
			factor_c   = FACTOR_W'(1);
		end else begin
			node_set_c = {{(NODE_SET_W-SET_W){1'b0}}, plural_c};
			if ({1'b0, slots_s2} >= sub_c) begin
				factor_c = FACTOR_W'({1'b0, slots_s2} - sub_c);
			end else begin
				factor_c = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			node_set_s3 <= node_set_c;
			factor_s3   <= factor_c;
			cost_s3     <= cost_s2;
			weight_s3   <= weight_s2;
		end
	end

	assign prod_c  = PROD_W'(weight_s3) * PROD_W'(factor_s3);
	assign total_c = TOTAL_W'(cost_s3) + TOTAL_W'(prod_c);

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			node_set_s4 <= node_set_s3;
			if (total_c[TOTAL_W-1:COST_W] != '0) begin
				node_cost_s4 <= COST_MAX;
			end else begin
				node_cost_s4 <= total_c[COST_W-1:0];
			end
		end
	end

	assign out_valid = v_s4;
	assign node_set  = node_set_s4;
	assign node_cost = node_cost_s4;

	a_no_child_no_cost: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && node_set == SET_NONE |-> node_cost == '0)
		else $error("Result without present slots carries a nonzero cost.");

	a_set_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && node_set[NODE_SET_W-1:SET_W] != '0 |-> node_set == SET_NONE)
		else $error("Result state set has stray upper bits.");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && v_s2 && v_s3 && v_s4 && out_stall)
		else $error("Input stalled while the pipeline has a free stage.");

endmodule

### rtl/core/fpnc_slot_prep.sv
// ----------------------------------------------------------------------------
// fpnc_slot_prep
// First-stage slot logic: effective slot count, presence, root detection,
// folded intersection, masked slot sets and the two half sums of the costs.
// ----------------------------------------------------------------------------
module fpnc_slot_prep
	import fpnc_pkg::*;
(
	input  logic [SLOT_W-1:0] slot_count,
	input  logic [MASK_W-1:0] present_mask,
	input  logic              transversion_mode,
	input  set_t              sets [MAX_CHILDREN],
	input  cost_t             costs [MAX_CHILDREN],
	output set_t              sets_masked [MAX_CHILDREN],
	output prep_t             prep
);

	logic [SLOT_W-1:0]       slots_eff;
	logic [MAX_CHILDREN-1:0] pres;

	always_comb begin
		set_t s;
		if (slot_count > SLOT_W'(MAX_CHILDREN)) begin
			slots_eff = SLOT_W'(MAX_CHILDREN);
		end else begin
			slots_eff = slot_count;
		end
		prep.slots = slots_eff;
		prep.root  = 1'b0;
		prep.inter = SET_NONE;
		for (int k = 0; k < MAX_CHILDREN; k++) begin
			pres[k] = (SLOT_W'(k) < slots_eff) && present_mask[k];
			if ((SLOT_W'(k) < slots_eff) && !present_mask[k]) begin
				prep.root = 1'b1;
			end
			s = transversion_mode ? fold_set(sets[k]) : sets[k];
			if (pres[k]) begin
				prep.inter = prep.inter & {{(NODE_SET_W-SET_W){1'b0}}, s};
			end
			sets_masked[k] = pres[k] ? sets[k] : '0;
		end
		prep.sum_lo = '0;
		prep.sum_hi = '0;
		for (int k = 0; k < HALF; k++) begin
			prep.sum_lo = prep.sum_lo + (pres[k] ? PAIR_W'(costs[k]) : '0);
		end
		for (int k = HALF; k < MAX_CHILDREN; k++) begin
			prep.sum_hi = prep.sum_hi + (pres[k] ? PAIR_W'(costs[k]) : '0);
		end
	end

endmodule
